[rtl/tsccr_pkg.sv]
// ----------------------------------------------------------------------------
// tsccr_pkg: shared types and constants of the TS continuity restamper
// Field widths, stream bus layout and the classified request that travels
// from the front stage through the queue to the back stage.
// ----------------------------------------------------------------------------
`default_nettype none

package tsccr_pkg;

    localparam int HDR_W   = 32;
    localparam int PID_W   = 13;
    localparam int CC_W    = 4;
    localparam int IDX_W   = 4;
    localparam int PID_LSB = 8;

    // Slave-side tdata layout, lowest bit first.
    localparam int HDR_LSB    = 0;
    localparam int REMAP_BIT  = HDR_LSB + HDR_W;
    localparam int SRC_LSB    = REMAP_BIT + 1;
    localparam int DST_LSB    = SRC_LSB + PID_W;
    localparam int EIDX_LSB   = DST_LSB + PID_W;
    localparam int EPID_LSB   = EIDX_LSB + IDX_W;
    localparam int EVALID_BIT = EPID_LSB + PID_W;
    localparam int ECNT_LSB   = EVALID_BIT + 1;
    localparam int S_FIELDS_W = ECNT_LSB + CC_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    localparam int M_TDATA_W  = HDR_W;
    localparam int M_TUSER_W  = 2;

    // Output tuser bit positions.
    localparam int PID_RW_BIT = 0;
    localparam int CC_RW_BIT  = 1;

    // Request kind codes carried in tuser.
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_RESTAMP = 1'b1;

    // Queue between front and back stages.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        logic             is_load;
        logic             lookup;
        logic             pid_rw;
        logic [PID_W-1:0] pid;
        logic [HDR_W-1:0] header;
        logic [IDX_W-1:0] entry_index;
        logic [PID_W-1:0] entry_pid;
        logic             entry_valid;
        logic [CC_W-1:0]  entry_counter;
        logic             eob;
    } item_t;

endpackage

`default_nettype wire

[rtl/tsccr_front.sv]
// ----------------------------------------------------------------------------
// tsccr_front: request classifier
// Unpacks a stream request, applies the PID remap and decides whether the
// back stage must look the PID up in the stream table.
// ----------------------------------------------------------------------------
`default_nettype none

module tsccr_front (
    input  wire logic [tsccr_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            s_tlast,
    output tsccr_pkg::item_t                     item
);
    import tsccr_pkg::*;

    logic [HDR_W-1:0] hdr;
    logic             remap;
    logic [PID_W-1:0] src_pid;
    logic [PID_W-1:0] dst_pid;
    logic [PID_W-1:0] hdr_pid;

    assign hdr     = s_tdata[HDR_LSB +: HDR_W];
    assign remap   = s_tdata[REMAP_BIT];
    assign src_pid = s_tdata[SRC_LSB +: PID_W];
    assign dst_pid = s_tdata[DST_LSB +: PID_W];
    assign hdr_pid = hdr[PID_LSB +: PID_W];

    always_comb
    begin
        item               = '0;
        item.entry_index   = s_tdata[EIDX_LSB +: IDX_W];
        item.entry_pid     = s_tdata[EPID_LSB +: PID_W];
        item.entry_valid   = s_tdata[EVALID_BIT];
        item.entry_counter = s_tdata[ECNT_LSB +: CC_W];
        item.eob           = s_tlast;
        item.header        = hdr;
        item.pid           = hdr_pid;

        if (s_tuser == FUNC_LOAD)
        begin
            item.is_load = 1'b1;
        end
        else if (remap)
        begin
            // Only packets of the source PID are touched when remapping.
            if (hdr_pid == src_pid)
            begin
                item.header[PID_LSB +: PID_W] = dst_pid;
                item.pid    = dst_pid;
                item.pid_rw = 1'b1;
                item.lookup = 1'b1;
            end
        end
        else
        begin
            item.lookup = 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/tsccr_queue.sv]
// ----------------------------------------------------------------------------
// tsccr_queue: short request queue
// A small FIFO of classified requests that decouples the front stage from
// the back stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tsccr_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  tsccr_pkg::item_t  push_item,
    output logic              full,
    input  wire logic         pop,
    output logic              head_valid,
    output tsccr_pkg::item_t  head_item
);
    import tsccr_pkg::*;

    item_t                  slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/tsccr_back.sv]
// ----------------------------------------------------------------------------
// tsccr_back: stream table and restamp stage
// Holds the associative PID table, performs loads and lookups and restamps
// the continuity counter into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsccr_back #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          head_valid,
    input  tsccr_pkg::item_t                   head_item,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tsccr_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [tsccr_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                               m_tlast
);
    import tsccr_pkg::*;

    logic [PID_W-1:0]         pid_reg   [TABLE_ENTRIES];
    logic [CC_W-1:0]          cnt_reg   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [TABLE_ENTRIES-1:0] match;
    logic [TABLE_ENTRIES-1:0] first_hit;
    logic [CC_W-1:0]          sel_cnt;
    logic                     any_hit;
    logic                     stamp;

    logic                     out_valid_reg;
    logic [HDR_W-1:0]         hdr_out_reg;
    logic                     pid_rw_reg;
    logic                     cc_rw_reg;
    logic                     eob_reg;

    assign pop = head_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (pid_reg[i] == head_item.pid);
        end
        // Lowest matching slot wins.
        first_hit = match & (~match + TABLE_ENTRIES'(1));
        sel_cnt   = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            sel_cnt = sel_cnt | (first_hit[i] ? cnt_reg[i] : '0);
        end
        any_hit = |match;
        stamp   = !head_item.is_load && head_item.lookup && any_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                pid_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (head_item.is_load)
                begin
                    // Slots past the end of the table never compare equal.
                    if (int'(head_item.entry_index) == i)
                    begin
                        pid_reg[i]   <= head_item.entry_pid;
                        valid_reg[i] <= head_item.entry_valid;
                        cnt_reg[i]   <= head_item.entry_counter;
                    end
                end
                else if (stamp && first_hit[i])
                begin
                    cnt_reg[i] <= cnt_reg[i] + CC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hdr_out_reg <= stamp ? {head_item.header[HDR_W-1:CC_W], sel_cnt}
                                 : head_item.header;
            pid_rw_reg  <= head_item.pid_rw;
            cc_rw_reg   <= stamp;
            eob_reg     <= head_item.eob;
        end
    end

    assign m_tvalid             = out_valid_reg;
    assign m_tdata              = hdr_out_reg;
    assign m_tuser[PID_RW_BIT]  = pid_rw_reg;
    assign m_tuser[CC_RW_BIT]   = cc_rw_reg;
    assign m_tlast              = eob_reg;

endmodule

`default_nettype wire

[rtl/ts_continuity_counter_restamper.sv]
// ----------------------------------------------------------------------------
// ts_continuity_counter_restamper: MPEG TS header PID remap and CC restamp
// Rewrites the 4-byte header of each transport stream packet, optionally
// remapping one PID, and stamps the continuity counter from a PID table.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Carries
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | load or restamp request, tlast = end of buffer
//  m_axis   | out       | rewritten header and rewrite flags, one per request
//
// Every request yields exactly one result. One request is accepted per clock
// cycle while s_axis_tready is high; the table lookup, the priority pick and
// the counter update happen in the same back stage cycle; a request passes
// through the queue write, then the back stage output register.
// Reset clears the table to all invalid and empties the queue and the output.
// A stall on m_axis fills the output register and then the two-entry queue
// before s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_continuity_counter_restamper #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, lowest bit first: header_word[31:0], remap_enable[32],
    // source_pid[45:33], dest_pid[58:46], entry_index[62:59],
    // entry_pid[75:63], entry_valid[76], entry_counter[80:77], zero padding.
    input  wire logic [tsccr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: func[0] (0 = load a table entry, 1 = restamp a packet header).
    input  wire logic                            s_axis_tuser,
    input  wire logic                            s_axis_tlast,

    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata: header_out[31:0].
    output logic [tsccr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // tuser, lowest bit first: pid_rewritten[0], counter_rewritten[1].
    output logic [tsccr_pkg::M_TUSER_W-1:0]      m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import tsccr_pkg::*;

    item_t front_item;
    item_t head_item;
    logic  queue_full;
    logic  head_valid;
    logic  pop;

    // The front stage classifies the request combinationally on its way
    // into the queue: remap decision, rewritten PID and lookup flag.
    tsccr_front u_front (
        .s_tdata (s_axis_tdata),
        .s_tuser (s_axis_tuser),
        .s_tlast (s_axis_tlast),
        .item    (front_item)
    );

    assign s_axis_tready = !queue_full;

    tsccr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_axis_tvalid),
        .push_item  (front_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // The back stage owns the table; requests reach it strictly in order, so
    // a counter advanced by one packet is seen by the very next one.
    tsccr_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .m_tlast    (m_axis_tlast)
    );

endmodule

`default_nettype wire
